// ----- src/pcf_pkg.sv -----
`default_nettype none
package pcf_pkg;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_CHUNK   = 2'd1;
  localparam logic [1:0] ST_CHUNK_OPEN = 2'd2;

  // command kinds passed from front to back
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_ERR   = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [31:0] chunk_type;
    logic [30:0] chunk_length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] status;
  } frame_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        tail;     // crc follows and closes the chunk
    logic [1:0]  status;
    logic [31:0] chunk_type;
    logic [30:0] chunk_length;
    logic [7:0]  data_byte;
  } cmd_t;

endpackage
`default_nettype wire

// ----- src/pcf_front.sv -----
`default_nettype none
module pcf_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_stall,
  input  wire pcf_pkg::item_t item,
  input  wire logic          q_full,
  output logic               q_push,
  output pcf_pkg::cmd_t      q_cmd
);
  import pcf_pkg::*;

  logic        chunk_open, chunk_open_next;
  logic [30:0] remaining, remaining_next;
  logic        accept;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;
  assign q_push     = accept;

  always_comb begin
    q_cmd              = '0;
    q_cmd.chunk_type   = item.chunk_type;
    q_cmd.chunk_length = item.chunk_length;
    q_cmd.data_byte    = item.data_byte;
    q_cmd.status       = ST_OK;
    chunk_open_next    = chunk_open;
    remaining_next     = remaining;
    if (!item.operation) begin
      if (chunk_open) begin
        q_cmd.kind   = CMD_ERR;
        q_cmd.status = ST_CHUNK_OPEN;
      end else begin
        q_cmd.kind      = CMD_BEGIN;
        q_cmd.tail      = (item.chunk_length == '0);
        chunk_open_next = (item.chunk_length != '0);
        remaining_next  = item.chunk_length;
      end
    end else begin
      if (!chunk_open) begin
        q_cmd.kind   = CMD_ERR;
        q_cmd.status = ST_NO_CHUNK;
      end else begin
        q_cmd.kind      = CMD_DATA;
        q_cmd.tail      = (remaining == 31'd1);
        chunk_open_next = (remaining != 31'd1);
        remaining_next  = remaining - 31'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_open <= 1'b0;
      remaining  <= '0;
    end else if (accept) begin
      chunk_open <= chunk_open_next;
      remaining  <= remaining_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/pcf_queue.sv -----
`default_nettype none
module pcf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire pcf_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output pcf_pkg::cmd_t      head
);
  import pcf_pkg::*;

  cmd_t           entries [QDepth];
  logic [QAw-1:0] wr_ptr, rd_ptr;
  logic [QAw:0]   count;
  logic           do_push, do_pop;

  assign full       = (count == QDepth[QAw:0]);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/pcf_back.sv -----
`default_nettype none
module pcf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire pcf_pkg::cmd_t head,
  output logic               pop,
  output logic               frame_valid,
  input  wire logic          frame_stall,
  output pcf_pkg::frame_t    frame
);
  import pcf_pkg::*;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // big-endian byte pick, position 0 is the top byte
  function automatic logic [7:0] pick(input logic [31:0] w, input logic [1:0] pos);
    logic [7:0] r;
    unique case (pos)
      2'd0: r = w[31:24];
      2'd1: r = w[23:16];
      2'd2: r = w[15:8];
      2'd3: r = w[7:0];
    endcase
    return r;
  endfunction

  logic [31:0] crc, crc_next;
  logic [3:0]  idx;
  logic        load, done;
  frame_t      emit;
  logic [31:0] crc_final;
  logic [31:0] len_word;

  assign load      = head_valid && (!frame_valid || !frame_stall);
  assign pop       = load && done;
  assign crc_final = crc ^ CRC_ONES;
  assign len_word  = {1'b0, head.chunk_length};

  always_comb begin
    emit     = '0;
    done     = 1'b0;
    crc_next = crc;
    unique case (head.kind)
      CMD_DATA: begin
        if (idx == 4'd0) begin
          emit.out_byte = head.data_byte;
          crc_next      = crc_byte(crc, head.data_byte);
          if (!head.tail) begin
            emit.last = 1'b1;
            done      = 1'b1;
          end
        end else begin
          emit.out_byte = pick(crc_final, idx[1:0] - 2'd1);
          if (idx == 4'd4) begin
            emit.last = 1'b1;
            done      = 1'b1;
            crc_next  = CRC_ONES;
          end
        end
      end
      CMD_BEGIN: begin
        if (idx < 4'd4) begin
          // fold one type byte per length byte sent
          emit.out_byte = pick(len_word, idx[1:0]);
          crc_next      = crc_byte((idx == 4'd0) ? CRC_ONES : crc,
                                   pick(head.chunk_type, idx[1:0]));
        end else if (idx < 4'd8) begin
          emit.out_byte = pick(head.chunk_type, idx[1:0]);
          if (idx == 4'd7 && !head.tail) begin
            emit.last = 1'b1;
            done      = 1'b1;
          end
        end else begin
          emit.out_byte = pick(crc_final, idx[1:0]);
          if (idx == 4'd11) begin
            emit.last = 1'b1;
            done      = 1'b1;
            crc_next  = CRC_ONES;
          end
        end
      end
      default: begin
        emit.status = head.status;
        emit.last   = 1'b1;
        done        = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc         <= CRC_ONES;
      idx         <= '0;
      frame_valid <= 1'b0;
    end else begin
      if (load) begin
        crc         <= crc_next;
        idx         <= done ? 4'd0 : idx + 4'd1;
        frame_valid <= 1'b1;
      end else if (!frame_stall) begin
        frame_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= emit;
    end
  end

endmodule
`default_nettype wire

// ----- src/png_chunk_framer_crc32.sv -----
// an item is written into the command queue, and its first word is registered
// into the output frame when the back end is idle
// one word per cycle while frame_stall is low; a data byte gives 1 word, the
// closing data byte 5, a begin 8 (12 for an empty chunk), a misuse status word 1
// a four-entry command queue lets items be taken while a burst is still going out
// reset clears the chunk tracking, queue pointers, crc and output valid at once
`default_nettype none
module png_chunk_framer_crc32 (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire pcf_pkg::item_t  item,
  output logic                 frame_valid,
  input  wire logic            frame_stall,
  output pcf_pkg::frame_t      frame
);
  import pcf_pkg::*;

  logic q_full, q_push, q_pop, head_valid;
  cmd_t q_cmd, head;

  pcf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  pcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  pcf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (q_pop),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame)
  );

endmodule
`default_nettype wire
